/* src/svpwm_pkg.sv */
// ----------------------------------------------------------------------------
// Space vector PWM duty package
// Shared widths, constants, sector codes and the output rounding function.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam int IN_W   = 16;
    localparam int KA_W   = 31;   // alpha * sqrt(3)/2 in Q.30
    localparam int T_W    = 33;   // active times t1, t2 in Q.30
    localparam int D_W    = 34;   // remapped duties before rounding

    localparam logic [14:0] SQ3_HALF_Q15 = 15'd28378;

    typedef logic [2:0] sector_t;

    localparam sector_t SECTOR_NONE = 3'd0;
    localparam sector_t SECTOR_1    = 3'd1;
    localparam sector_t SECTOR_2    = 3'd2;
    localparam sector_t SECTOR_3    = 3'd3;
    localparam sector_t SECTOR_4    = 3'd4;
    localparam sector_t SECTOR_5    = 3'd5;
    localparam sector_t SECTOR_6    = 3'd6;

    typedef struct packed {
        sector_t                sector;
        logic signed [T_W-1:0]  t1;
        logic signed [T_W-1:0]  t2;
    } sector_times_t;

    // Q.30 to Q1.15, round half up, then saturate
    function automatic logic signed [IN_W-1:0] to_q15(input logic signed [D_W-1:0] v);
        logic signed [D_W:0]    s;
        logic signed [D_W-15:0] r;
        logic signed [IN_W-1:0] q;
        s = {v[D_W-1], v} + $signed((D_W+1)'(16384));
        r = s[D_W:15];
        if (r > $signed((D_W-14)'(32767))) begin
            q = 16'sh7fff;
        end else if (r < -$signed((D_W-14)'(32768))) begin
            q = 16'sh8000;
        end else begin
            q = r[IN_W-1:0];
        end
        return q;
    endfunction

endpackage

/* src/svpwm_sector.sv */
// ----------------------------------------------------------------------------
// Space vector PWM sector and active time selection
// Finds the 60-degree sector from the projection signs and picks t1, t2.
// ----------------------------------------------------------------------------
module svpwm_sector (
    input  logic signed [svpwm_pkg::KA_W-1:0] k_a,
    input  logic signed [svpwm_pkg::IN_W-1:0] v_beta,
    output svpwm_pkg::sector_times_t          times
);
    import svpwm_pkg::*;

    logic signed [T_W-1:0] half_b;
    logic signed [T_W-1:0] x;
    logic signed [T_W-1:0] ka_ext;
    logic signed [T_W-1:0] y;
    logic signed [T_W-1:0] z;
    sector_t               sector;

    always_comb begin
        half_b = T_W'(v_beta) <<< 14;
        x      = T_W'(v_beta) <<< 15;
        ka_ext = T_W'(k_a);
        y      = half_b + ka_ext;
        z      = half_b - ka_ext;
        // z < 0 means k_a - beta/2 > 0, y < 0 means -beta/2 - k_a > 0
        sector = {y[T_W-1], z[T_W-1], (!x[T_W-1]) && (x != '0)};

        times.sector = sector;
        times.t1     = '0;
        times.t2     = '0;
        case (sector)
            SECTOR_1: begin times.t1 = z;  times.t2 = y;  end
            SECTOR_2: begin times.t1 = y;  times.t2 = -x; end
            SECTOR_3: begin times.t1 = -z; times.t2 = x;  end
            SECTOR_4: begin times.t1 = -x; times.t2 = z;  end
            SECTOR_5: begin times.t1 = x;  times.t2 = -y; end
            SECTOR_6: begin times.t1 = -y; times.t2 = -z; end
            default:  begin times.t1 = '0; times.t2 = '0; end
        endcase
    end

endmodule

/* src/space_vector_pwm_duty_top.sv */
// ----------------------------------------------------------------------------
// Space vector PWM duty generator
// Turns an alpha/beta voltage vector into three saturated phase duties.
// ----------------------------------------------------------------------------
// Takes one (v_alpha, v_beta) vector per cycle in signed Q1.15 and returns
// three phase duties (A, B, C) in signed Q1.15, saturated; a pure beta vector
// leaves phase A at zero. There are three register stages from input transfer
// to output valid: one for the sqrt(3)/2 multiply, one for sector and active
// times, one for the duty sums with rounding. Throughput is one vector per clock
// without back-pressure; each stage holds its item under back-pressure and moves as soon as the next frees up.
module space_vector_pwm_duty_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] v_alpha, [31:16] v_beta
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c
);
    import svpwm_pkg::*;

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  adv1, adv2, adv3;
    logic signed [KA_W-1:0] ka_reg;
    logic signed [IN_W-1:0] beta_reg;
    sector_times_t          times;
    sector_times_t          times_reg;
    logic signed [D_W-1:0]  first, second, third;
    logic signed [D_W-1:0]  da, db, dc;
    logic [47:0]            out_next;
    logic [47:0]            out_reg;
    logic signed [IN_W-1:0] alpha_in;
    logic signed [IN_W-1:0] beta_in;
    logic signed [KA_W-1:0] ka_next;

    // a stage moves when its successor is empty or moving
    assign adv3          = !v3_reg || m_axis_tready;
    assign adv2          = !v2_reg || adv3;
    assign adv1          = !v1_reg || adv2;
    assign s_axis_tready = adv1;

    assign alpha_in = s_axis_tdata[15:0];
    assign beta_in  = s_axis_tdata[31:16];
    // widen both operands so the product keeps all of its bits
    assign ka_next  = KA_W'(alpha_in) * KA_W'($signed({1'b0, SQ3_HALF_Q15}));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_axis_tvalid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && s_axis_tvalid) begin
            ka_reg   <= ka_next;
            beta_reg <= beta_in;
        end
        if (adv2 && v1_reg) begin
            times_reg <= times;
        end
        if (adv3 && v2_reg) begin
            out_reg <= out_next;
        end
    end

    svpwm_sector u_sector (
        .k_a    (ka_reg),
        .v_beta (beta_reg),
        .times  (times)
    );

    always_comb begin
        first  = -D_W'(times_reg.t1) - D_W'(times_reg.t2);
        second =  D_W'(times_reg.t1) - D_W'(times_reg.t2);
        third  =  D_W'(times_reg.t1) + D_W'(times_reg.t2);
        da = '0;
        db = '0;
        dc = '0;
        case (times_reg.sector)
            SECTOR_1: begin db = first; da = second; dc = third; end
            SECTOR_2: begin da = first; dc = second; db = third; end
            SECTOR_3: begin da = first; db = second; dc = third; end
            SECTOR_4: begin dc = first; db = second; da = third; end
            SECTOR_5: begin db = first; dc = second; da = third; end
            SECTOR_6: begin dc = first; da = second; db = third; end
            default:  begin da = '0; db = '0; dc = '0; end
        endcase
        out_next = {to_q15(dc), to_q15(db), to_q15(da)};
    end

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = out_reg;

endmodule

/* tb/sv/tb_space_vector_pwm_duty_top.sv */
// ----------------------------------------------------------------------------
// Space vector PWM duty generator testbench
// Drives alpha/beta vectors through the stream input with random idle cycles
// on both sides. Each duty set that comes out is checked field by field
// against typed duties or a bit-exact duty predictor, in transfer order.
// ----------------------------------------------------------------------------
module tb_space_vector_pwm_duty_top;

    import svpwm_pkg::*;

    localparam int          CLK_HALF      = 6;
    localparam int          RESET_CYCLES  = 7;
    localparam int          RANDOM_ITEMS  = 1800;
    localparam int          STEADY_FROM   = 600;
    localparam int          STEADY_TO     = 1000;
    localparam int          IDLE_PERCENT  = 36;
    localparam int          DRAIN_CYCLES  = 8;
    localparam int          MAX_REPORTS   = 10;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam longint      SQRT3_HALF    = 28378;   // sqrt(3)/2 in Q1.15
    localparam int          N_DIRECTED    = 25;

    // duties in the same order as m_axis_tdata, phase A in the low bits
    typedef struct packed {
        logic signed [15:0] c;
        logic signed [15:0] b;
        logic signed [15:0] a;
    } duty_set_t;

    typedef struct packed {
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        bit                 known;
        duty_set_t          duties;
    } vec_row_t;

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;   // [15:0] v_alpha, [31:16] v_beta
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;         // [15:0] duty_a, [31:16] duty_b, [47:32] duty_c

    duty_set_t   duty_queue [$];
    bit          steady_run    = 1'b0;
    int unsigned cycle_count   = 0;
    int unsigned errors        = 0;
    int unsigned vectors_sent  = 0;
    int unsigned duties_seen   = 0;
    int unsigned saturated     = 0;
    int unsigned sector_hits [0:7] = '{default: 0};

    // zero vector and pure beta extremes carry typed duties, the rest go
    // through the predictor
    vec_row_t directed_rows [0:N_DIRECTED-1] = '{
        {16'sd0,      16'sd0,      1'b1, {16'sd0,      16'sd0,      16'sd0}},
        {16'sd0,      16'sd32767,  1'b1, {16'sd32767,  -16'sd32767, 16'sd0}},
        {16'sd0,      -16'sd32768, 1'b1, {-16'sd32768, 16'sd32767,  16'sd0}},
        {16'sd32767,  16'sd0,      1'b0, 48'd0},
        {-16'sd32768, 16'sd0,      1'b0, 48'd0},
        {16'sd32767,  16'sd32767,  1'b0, 48'd0},
        {-16'sd32768, -16'sd32768, 1'b0, 48'd0},
        {-16'sd32768, 16'sd32767,  1'b0, 48'd0},
        {16'sd32767,  -16'sd32768, 1'b0, 48'd0},
        {16'sd16000,  16'sd0,      1'b0, 48'd0},
        {16'sd13856,  16'sd8000,   1'b0, 48'd0},
        {16'sd8000,   16'sd13856,  1'b0, 48'd0},
        {16'sd0,      16'sd16000,  1'b0, 48'd0},
        {-16'sd8000,  16'sd13856,  1'b0, 48'd0},
        {-16'sd13856, 16'sd8000,   1'b0, 48'd0},
        {-16'sd16000, 16'sd0,      1'b0, 48'd0},
        {-16'sd13856, -16'sd8000,  1'b0, 48'd0},
        {-16'sd8000,  -16'sd13856, 1'b0, 48'd0},
        {16'sd0,      -16'sd16000, 1'b0, 48'd0},
        {16'sd8000,   -16'sd13856, 1'b0, 48'd0},
        {16'sd13856,  -16'sd8000,  1'b0, 48'd0},
        {16'sd8192,   16'sd14189,  1'b0, 48'd0},
        {-16'sd8192,  16'sd14189,  1'b0, 48'd0},
        {16'sd0,      16'sd1,      1'b0, 48'd0},
        {16'sd1,      16'sd0,      1'b0, 48'd0}
    };

    space_vector_pwm_duty_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    // Q.30 to Q1.15: round half up, then clamp
    function automatic logic signed [15:0] round_to_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return 16'(r);
    endfunction

    function automatic duty_set_t predict_duties(input logic signed [15:0] v_alpha,
                                                 input logic signed [15:0] v_beta,
                                                 output sector_t sector);
        longint    half_b, k_a, x, y, z, t1, t2, d_lead, d_mid, d_tail;
        duty_set_t d;
        half_b = longint'(v_beta) * 16384;
        k_a    = longint'(v_alpha) * SQRT3_HALF;
        x      = longint'(v_beta) * 32768;
        y      = half_b + k_a;
        z      = half_b - k_a;
        t1     = 0;
        t2     = 0;
        sector = SECTOR_NONE;
        if (x > 0)             sector[0] = 1'b1;
        if (k_a - half_b > 0)  sector[1] = 1'b1;
        if (-half_b - k_a > 0) sector[2] = 1'b1;
        case (sector)
            SECTOR_1: begin t1 = z;  t2 = y;  end
            SECTOR_2: begin t1 = y;  t2 = -x; end
            SECTOR_3: begin t1 = -z; t2 = x;  end
            SECTOR_4: begin t1 = -x; t2 = z;  end
            SECTOR_5: begin t1 = x;  t2 = -y; end
            SECTOR_6: begin t1 = -y; t2 = -z; end
            default: ;
        endcase
        // remapped duties 2*d-1, formed exactly
        d_lead = -t1 - t2;
        d_mid  = t1 - t2;
        d_tail = t1 + t2;
        d = '0;
        case (sector)
            SECTOR_1: begin
                d.b = round_to_q15(d_lead); d.a = round_to_q15(d_mid); d.c = round_to_q15(d_tail);
            end
            SECTOR_2: begin
                d.a = round_to_q15(d_lead); d.c = round_to_q15(d_mid); d.b = round_to_q15(d_tail);
            end
            SECTOR_3: begin
                d.a = round_to_q15(d_lead); d.b = round_to_q15(d_mid); d.c = round_to_q15(d_tail);
            end
            SECTOR_4: begin
                d.c = round_to_q15(d_lead); d.b = round_to_q15(d_mid); d.a = round_to_q15(d_tail);
            end
            SECTOR_5: begin
                d.b = round_to_q15(d_lead); d.c = round_to_q15(d_mid); d.a = round_to_q15(d_tail);
            end
            SECTOR_6: begin
                d.c = round_to_q15(d_lead); d.a = round_to_q15(d_mid); d.b = round_to_q15(d_tail);
            end
            default: ;
        endcase
        return d;
    endfunction

    // called at a rising edge; returns at the edge of the transfer
    task automatic send_vector(input logic signed [15:0] alpha,
                               input logic signed [15:0] beta,
                               input bit                 typed,
                               input duty_set_t          typed_duties);
        duty_set_t predicted;
        sector_t   sector;
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {beta, alpha};
        @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
        @(posedge aclk);
        predicted = predict_duties(alpha, beta, sector);
        sector_hits[sector]++;
        if (predicted.a inside {16'sh7fff, 16'sh8000} || predicted.b inside {16'sh7fff, 16'sh8000}
            || predicted.c inside {16'sh7fff, 16'sh8000}) begin
            saturated++;
        end
        duty_queue.push_back(typed ? typed_duties : predicted);
        vectors_sent++;
    endtask

    task automatic check_duties(input duty_set_t got);
        duty_set_t want;
        duties_seen++;
        if (duty_queue.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("[%0d] unexpected duty transfer a=%0d b=%0d c=%0d",
                         cycle_count, got.a, got.b, got.c);
            end
        end else begin
            want = duty_queue.pop_front();
            if (got.a !== want.a || got.b !== want.b || got.c !== want.c) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("[%0d] duty mismatch: expected a=%0d b=%0d c=%0d, got a=%0d b=%0d c=%0d",
                             cycle_count, want.a, want.b, want.c, got.a, got.b, got.c);
                end
            end
        end
    endtask

    // output transfer happens at the next rising edge; data is stable here
    always @(negedge aclk) begin
        if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            check_duties(duty_set_t'(m_axis_tdata));
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= aresetn && (steady_run || $urandom_range(99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d duty sets pending",
                     cycle_count, duty_queue.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int             pick;
        int             m;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_vector(directed_rows[i].alpha, directed_rows[i].beta,
                        directed_rows[i].known, directed_rows[i].duties);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady_run <= (i >= STEADY_FROM && i < STEADY_TO);
            pick = $urandom_range(9);
            if (pick <= 4) begin
                alpha = 16'($urandom);
                beta  = 16'($urandom);
            end else if (pick <= 7) begin
                // inside the linear range
                alpha = 16'(int'($urandom_range(46340)) - 23170);
                beta  = 16'(int'($urandom_range(46340)) - 23170);
            end else if (pick == 8) begin
                // tiny vectors exercise the rounding ties
                alpha = 16'(int'($urandom_range(128)) - 64);
                beta  = 16'(int'($urandom_range(128)) - 64);
            end else begin
                // sector boundaries: the three projections hit zero
                m = int'($urandom_range(4)) - 2;
                case ($urandom_range(2))
                    0: begin alpha = 16'(8192 * m);  beta = 16'(14189 * m); end
                    1: begin alpha = 16'(-8192 * m); beta = 16'(14189 * m); end
                    default: begin alpha = 16'($urandom); beta = 16'sd0; end
                endcase
            end
            send_vector(alpha, beta, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        steady_run    <= 1'b0;

        wait (duty_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d vectors (%0d directed), %0d duty sets compared, %0d saturated",
                 vectors_sent, N_DIRECTED, duties_seen, saturated);
        $display("sector hits: none=%0d s1=%0d s2=%0d s3=%0d s4=%0d s5=%0d s6=%0d, mismatches=%0d",
                 sector_hits[0], sector_hits[1], sector_hits[2], sector_hits[3],
                 sector_hits[4], sector_hits[5], sector_hits[6], errors);
        if (errors == 0 && duty_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
